/* rtl/wses_pkg.sv */
// ----------------------------------------------------------------------------
// wses_pkg
// Shared types and constants of the watermark spill eviction table.
// ----------------------------------------------------------------------------
package wses_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned SIZE_W = 40;
  localparam int unsigned COLD_W = 32;
  localparam int unsigned TOT_W  = 44;
  localparam int unsigned WM_W   = 17;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned PROD_W = SIZE_W + WM_W;
  localparam int unsigned THR_W  = PROD_W - 16;

  localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PIN        = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UNPIN      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SPILL      = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_SPILL  = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_SPILL_EN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BUDGET   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HIGH_WM  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_LOW_WM   = 2'd3;

  typedef struct packed {
    logic latch;
    logic rd_slot;
    logic apply;
    logic sum_clr;
    logic pick_clr;
    logic scan;
    logic scan_pick;
    logic mul;
    logic load_skip;
    logic skip_zero;
    logic load_none;
    logic evict;
    logic set_last;
    logic show;
  } cmd_t;

  typedef struct packed {
    logic is_spill;
    logic spill_off;
    logic no_need;
    logic have;
    logic over_low;
    logic idx_last;
    logic out_busy;
  } stat_t;

endpackage

/* rtl/wses_ram.sv */
// ----------------------------------------------------------------------------
// wses_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wses_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wses_dp.sv */
// ----------------------------------------------------------------------------
// wses_dp
// Datapath: configuration, slot table, scan accumulators and result word.
// ----------------------------------------------------------------------------
module wses_dp import wses_pkg::*; #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned PIN_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_addr_i,
  input  logic [SIZE_W-1:0]        cfg_wdata_i,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  logic [SIZE_W-1:0]        size_in_i,
  input  logic [COLD_W-1:0]        coldness_in_i,
  input  logic                     out_take_i,
  output logic                     out_valid_o,
  output logic [STAT_W-1:0]        status_o,
  output logic                     reloaded_o,
  output logic                     evict_valid_o,
  output logic [SLOT_W-1:0]        evict_slot_o,
  output logic [TOT_W-1:0]         freed_total_o,
  output logic [TOT_W-1:0]         resident_total_o,
  output logic                     last_o
);

  localparam int unsigned SW = $clog2(SLOTS);

  logic              en_q;
  logic [SIZE_W-1:0] budget_q;
  logic [WM_W-1:0]   hwm_q, lwm_q;

  logic [REQ_W-1:0]  type_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SIZE_W-1:0] size_q;
  logic [COLD_W-1:0] cold_q;

  logic [SLOTS-1:0]  valid_q, evict_q;
  logic [SW-1:0]     idx_q, pidx_q;
  logic              pv_q, pmode_q;
  logic [TOT_W-1:0]  total_q, freed_q;
  logic [THR_W-1:0]  high_q, low_q;
  logic              have_q;
  logic [SW-1:0]     best_idx_q;
  logic [COLD_W-1:0] best_cold_q;
  logic [SIZE_W-1:0] best_bytes_q;

  logic              ovalid_q;
  logic [STAT_W-1:0] ostat_q;
  logic              orel_q, oev_q, olast_q;
  logic [SLOT_W-1:0] oslot_q;
  logic [TOT_W-1:0]  ofreed_q, ores_q;

  logic [SW-1:0]       sidx;
  logic                in_range, known;
  logic [SIZE_W-1:0]   bytes_rd;
  logic [COLD_W-1:0]   cold_rd;
  logic [PIN_BITS-1:0] pins_rd, pins_wd;
  logic                pins_we, tab_we, live, cand;
  logic [SW-1:0]       raddr;
  logic [PROD_W-1:0]   hprod, lprod;
  logic [TOT_W-1:0]    freed_nx;
  logic [STAT_W-1:0]   a_stat;
  logic                a_rel;

  assign sidx     = SW'(slot_q);
  assign in_range = 32'(slot_q) < SLOTS;
  assign known    = in_range && valid_q[sidx];
  assign raddr    = cmd_i.scan ? idx_q : sidx;
  assign tab_we   = cmd_i.apply && (type_q == REQ_REGISTER) && in_range;
  assign live     = valid_q[pidx_q] && !evict_q[pidx_q];
  assign cand     = live && (pins_rd == '0);
  assign hprod    = PROD_W'(budget_q) * PROD_W'(hwm_q);
  assign lprod    = PROD_W'(budget_q) * PROD_W'(lwm_q);
  assign freed_nx = freed_q + TOT_W'(best_bytes_q);

  // decode the single-result requests
  always_comb begin
    a_stat  = ST_IGNORED;
    a_rel   = 1'b0;
    pins_we = 1'b0;
    pins_wd = '0;
    unique case (type_q)
      REQ_REGISTER: begin
        if (in_range) begin
          a_stat  = ST_DONE;
          pins_we = 1'b1;
        end
      end
      REQ_UNREGISTER: begin
        if (known) a_stat = ST_DONE;
      end
      REQ_PIN: begin
        if (known) begin
          a_stat  = ST_DONE;
          a_rel   = evict_q[sidx];
          pins_we = 1'b1;
          pins_wd = (pins_rd == '1) ? pins_rd : pins_rd + 1'b1;
        end
      end
      REQ_UNPIN: begin
        if (known) begin
          if (pins_rd == '0) begin
            a_stat = ST_UNDERFLOW;
          end else begin
            a_stat  = ST_DONE;
            pins_we = 1'b1;
            pins_wd = pins_rd - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  wses_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_bytes (
    .clk_i, .we_i(tab_we), .waddr_i(sidx), .wdata_i(size_q),
    .re_i(cmd_i.rd_slot | cmd_i.scan), .raddr_i(raddr), .rdata_o(bytes_rd)
  );
  wses_ram #(.WIDTH(COLD_W), .DEPTH(SLOTS)) u_cold (
    .clk_i, .we_i(tab_we), .waddr_i(sidx), .wdata_i(cold_q),
    .re_i(cmd_i.rd_slot | cmd_i.scan), .raddr_i(raddr), .rdata_o(cold_rd)
  );
  wses_ram #(.WIDTH(PIN_BITS), .DEPTH(SLOTS)) u_pins (
    .clk_i, .we_i(cmd_i.apply && pins_we), .waddr_i(sidx), .wdata_i(pins_wd),
    .re_i(cmd_i.rd_slot | cmd_i.scan), .raddr_i(raddr), .rdata_o(pins_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      budget_q <= '0;
      hwm_q    <= WM_W'(52429);
      lwm_q    <= WM_W'(39322);
      valid_q  <= '0;
      evict_q  <= '0;
      pv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_SPILL_EN: en_q     <= cfg_wdata_i[0];
          CFG_BUDGET:   budget_q <= cfg_wdata_i;
          CFG_HIGH_WM:  hwm_q    <= cfg_wdata_i[WM_W-1:0];
          CFG_LOW_WM:   lwm_q    <= cfg_wdata_i[WM_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        if (tab_we) begin
          valid_q[sidx] <= 1'b1;
          evict_q[sidx] <= 1'b0;
        end else if (known && (type_q == REQ_UNREGISTER)) begin
          valid_q[sidx] <= 1'b0;
          evict_q[sidx] <= 1'b0;
        end else if (known && (type_q == REQ_PIN)) begin
          evict_q[sidx] <= 1'b0;
        end
      end
      if (cmd_i.evict) evict_q[best_idx_q] <= 1'b1;
      pv_q <= cmd_i.scan;
      if (cmd_i.sum_clr || cmd_i.pick_clr) begin
        idx_q <= '0;
      end else if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.show) begin
        ovalid_q <= 1'b1;
      end else if (out_take_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      type_q <= req_type_i;
      slot_q <= slot_i;
      size_q <= size_in_i;
      cold_q <= coldness_in_i;
    end
    pidx_q  <= idx_q;
    pmode_q <= cmd_i.scan_pick;
    if (cmd_i.sum_clr) begin
      total_q <= '0;
      freed_q <= '0;
    end else if (pv_q && !pmode_q && live) begin
      total_q <= total_q + TOT_W'(bytes_rd);
    end
    if (cmd_i.mul) begin
      high_q <= hprod[PROD_W-1:16];
      low_q  <= lprod[PROD_W-1:16];
    end
    if (cmd_i.pick_clr) begin
      have_q <= 1'b0;
    end else if (pv_q && pmode_q && cand && (!have_q || cold_rd < best_cold_q)) begin
      have_q       <= 1'b1;
      best_idx_q   <= pidx_q;
      best_cold_q  <= cold_rd;
      best_bytes_q <= bytes_rd;
    end
    // result word
    if (cmd_i.apply) begin
      ostat_q  <= a_stat;
      orel_q   <= a_rel;
      oev_q    <= 1'b0;
      oslot_q  <= '0;
      ofreed_q <= '0;
      ores_q   <= '0;
      olast_q  <= 1'b1;
    end else if (cmd_i.load_skip || cmd_i.load_none) begin
      ostat_q  <= cmd_i.load_skip ? ST_NO_SPILL : ST_DONE;
      orel_q   <= 1'b0;
      oev_q    <= 1'b0;
      oslot_q  <= '0;
      ofreed_q <= '0;
      ores_q   <= cmd_i.skip_zero ? '0 : total_q;
      olast_q  <= 1'b1;
    end else if (cmd_i.evict) begin
      ostat_q  <= ST_DONE;
      orel_q   <= 1'b0;
      oev_q    <= 1'b1;
      oslot_q  <= SLOT_W'(best_idx_q);
      ofreed_q <= freed_nx;
      ores_q   <= total_q;
      olast_q  <= 1'b0;
      freed_q  <= freed_nx;
    end else if (cmd_i.set_last) begin
      olast_q  <= 1'b1;
    end
  end

  assign stat_o.is_spill  = (type_q == REQ_SPILL);
  assign stat_o.spill_off = !en_q || (budget_q == '0);
  assign stat_o.no_need   = (total_q <= TOT_W'(high_q)) || (total_q <= TOT_W'(low_q));
  assign stat_o.have      = have_q;
  assign stat_o.over_low  = (total_q - freed_q) > TOT_W'(low_q);
  assign stat_o.idx_last  = (idx_q == SW'(SLOTS - 1));
  assign stat_o.out_busy  = ovalid_q;

  assign out_valid_o      = ovalid_q;
  assign status_o         = ostat_q;
  assign reloaded_o       = orel_q;
  assign evict_valid_o    = oev_q;
  assign evict_slot_o     = oslot_q;
  assign freed_total_o    = ofreed_q;
  assign resident_total_o = ores_q;
  assign last_o           = olast_q;

endmodule

/* rtl/wses_ctrl.sv */
// ----------------------------------------------------------------------------
// wses_ctrl
// Sequencer: request decode, table scans and eviction rounds.
// ----------------------------------------------------------------------------
module wses_ctrl import wses_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_APPLY, S_SUM, S_SUM_DRAIN, S_MUL, S_CMP, S_SKIP,
    S_PICK, S_PICK_DRAIN, S_PDEC, S_EVICT, S_CHK, S_NONE
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d, skipz_q, skipz_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    pend_d  = pend_q;
    skipz_d = skipz_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat_i.is_spill) begin
          cmd_o.rd_slot = 1'b1;
          state_d       = S_APPLY;
        end else if (stat_i.spill_off) begin
          skipz_d = 1'b1;
          state_d = S_SKIP;
        end else begin
          cmd_o.sum_clr = 1'b1;
          state_d       = S_SUM;
        end
      end
      S_APPLY: begin
        if (!stat_i.out_busy) begin
          cmd_o.apply = 1'b1;
          cmd_o.show  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SUM: begin
        cmd_o.scan = 1'b1;
        if (stat_i.idx_last) state_d = S_SUM_DRAIN;
      end
      S_SUM_DRAIN: state_d = S_MUL;
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (stat_i.no_need) begin
          skipz_d = 1'b0;
          state_d = S_SKIP;
        end else begin
          cmd_o.pick_clr = 1'b1;
          pend_d         = 1'b0;
          state_d        = S_PICK;
        end
      end
      S_SKIP: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_skip = 1'b1;
          cmd_o.skip_zero = skipz_q;
          cmd_o.show      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_PICK: begin
        cmd_o.scan      = 1'b1;
        cmd_o.scan_pick = 1'b1;
        if (stat_i.idx_last) state_d = S_PICK_DRAIN;
      end
      S_PICK_DRAIN: state_d = S_PDEC;
      S_PDEC: begin
        // release the held eviction word once the next round is known
        priority if (stat_i.have) begin
          cmd_o.show = pend_q;
          state_d    = S_EVICT;
        end else if (pend_q) begin
          cmd_o.set_last = 1'b1;
          cmd_o.show     = 1'b1;
          pend_d         = 1'b0;
          state_d        = S_IDLE;
        end else begin
          state_d = S_NONE;
        end
      end
      S_EVICT: begin
        if (!stat_i.out_busy) begin
          cmd_o.evict = 1'b1;
          pend_d      = 1'b1;
          state_d     = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.over_low) begin
          cmd_o.pick_clr = 1'b1;
          state_d        = S_PICK;
        end else begin
          cmd_o.set_last = 1'b1;
          cmd_o.show     = 1'b1;
          pend_d         = 1'b0;
          state_d        = S_IDLE;
        end
      end
      S_NONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_none = 1'b1;
          cmd_o.show      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      skipz_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      skipz_q <= skipz_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

/* rtl/watermark_spill_eviction_table.sv */
// ----------------------------------------------------------------------------
// watermark_spill_eviction_table
// Slot table with high/low watermark spill checks, coldest-first eviction.
// ----------------------------------------------------------------------------
// Input words on s_axis carry a request: register, unregister, pin, unpin or
// spill check. Result words leave on m_axis; tlast marks the final word of a
// request. Register, unregister, pin and unpin give one word each. A spill
// check first sweeps the table once, one slot a cycle through the slot RAM
// read port, then runs one picking sweep per eviction round; each eviction
// word leaves once it is known whether it is the last one, when the low
// watermark is reached or the next sweep has decided.
// One request is in work at a time; the next word is taken once the
// previous request has loaded its final result, which may still wait on
// m_axis. A stalled receiver holds the result word and keeps the next result
// from being loaded. The user must write configuration through cfg_we_i /
// cfg_addr_i / cfg_wdata_i only while the block is idle; the block itself
// leaves this to the user. Reset empties the table and loads the default
// configuration; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module watermark_spill_eviction_table import wses_pkg::*; #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned PIN_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_addr_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type[2:0], slot[6:3], size_in[46:7], coldness_in[78:47], zero[79]
  input  logic [79:0]       s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[1:0], reloaded[2], evict_valid[3], evict_slot[7:4],
  // freed_total[51:8], resident_total[95:52]
  output logic [95:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;
  logic  ovalid;

  wses_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wses_dp #(.SLOTS(SLOTS), .PIN_BITS(PIN_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .req_type_i       (s_axis_tdata[2:0]),
    .slot_i           (s_axis_tdata[6:3]),
    .size_in_i        (s_axis_tdata[46:7]),
    .coldness_in_i    (s_axis_tdata[78:47]),
    .out_take_i       (m_axis_tready),
    .out_valid_o      (ovalid),
    .status_o         (m_axis_tdata[1:0]),
    .reloaded_o       (m_axis_tdata[2]),
    .evict_valid_o    (m_axis_tdata[3]),
    .evict_slot_o     (m_axis_tdata[7:4]),
    .freed_total_o    (m_axis_tdata[51:8]),
    .resident_total_o (m_axis_tdata[95:52]),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tvalid = ovalid;

endmodule

/* tb/tb_watermark_spill_eviction_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_watermark_spill_eviction_table
// Self-checking bench for the watermark spill eviction table.
// A directed table runs first: requests on empty slots, pin underflow,
// coldness ties, reload on pin, nothing left to evict and spill disabled.
// Random traffic follows under several budget and watermark settings. A local
// slot table predicts every result word, and each word on m_axis is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_watermark_spill_eviction_table;
  import wses_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              reloaded;
    logic              evict_valid;
    logic [SLOT_W-1:0] evict_slot;
    logic [TOT_W-1:0]  freed_total;
    logic [TOT_W-1:0]  resident_total;
    logic              last;
  } result_t;

  typedef struct {
    bit                is_cfg;
    logic [CIDX_W-1:0] cidx;
    logic [SIZE_W-1:0] cval;
    logic [REQ_W-1:0]  req;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic [COLD_W-1:0] cold;
    bit                typed;
    logic [STAT_W-1:0] t_status;
    logic              t_reloaded;
  } step_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_addr_i = '0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [79:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;
  logic              m_axis_tlast;

  // predicted slot table and configuration
  logic              tbl_valid   [16];
  logic [SIZE_W-1:0] tbl_bytes   [16];
  logic [COLD_W-1:0] tbl_cold    [16];
  logic [15:0]       tbl_pins    [16];
  logic              tbl_evicted [16];
  logic              spill_en;
  logic [SIZE_W-1:0] budget;
  logic [WM_W-1:0]   high_wm;
  logic [WM_W-1:0]   low_wm;

  result_t pending_results[$];
  step_t   directed_steps[$];
  int      errors = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_left = 0;
  bit      big_sizes = 0;

  watermark_spill_eviction_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void expect_word(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_step(step_t t);
    directed_steps.insert(directed_steps.size(), t);
  endfunction

  function automatic result_t simple_result(logic [STAT_W-1:0] st, logic rl);
    result_t r;
    r = '0;
    r.status = st;
    r.reloaded = rl;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_spill();
    logic [63:0] total, freed, hi_b, lo_b;
    result_t     r, prev;
    bit          have_prev;
    int          pick;
    total = '0;
    freed = '0;
    have_prev = 0;
    if (!spill_en || budget == '0) begin
      expect_word(simple_result(ST_NO_SPILL, 1'b0));
      return;
    end
    for (int i = 0; i < 16; i++)
      if (tbl_valid[i] && !tbl_evicted[i]) total += 64'(tbl_bytes[i]);
    hi_b = (64'(budget) * 64'(high_wm)) >> 16;
    lo_b = (64'(budget) * 64'(low_wm)) >> 16;
    r = simple_result(ST_NO_SPILL, 1'b0);
    r.resident_total = total[TOT_W-1:0];
    if (total <= hi_b || total <= lo_b) begin
      expect_word(r);
      return;
    end
    while (total - freed > lo_b) begin
      pick = -1;
      for (int i = 0; i < 16; i++) begin
        if (!tbl_valid[i] || tbl_evicted[i] || tbl_pins[i] != 0) continue;
        if (pick < 0 || tbl_cold[i] < tbl_cold[pick]) pick = i;
      end
      if (pick < 0) break;
      tbl_evicted[pick] = 1'b1;
      freed += 64'(tbl_bytes[pick]);
      if (have_prev) expect_word(prev);
      prev = '0;
      prev.status = ST_DONE;
      prev.evict_valid = 1'b1;
      prev.evict_slot = pick[SLOT_W-1:0];
      prev.freed_total = freed[TOT_W-1:0];
      prev.resident_total = total[TOT_W-1:0];
      have_prev = 1;
    end
    if (have_prev) begin
      prev.last = 1'b1;
      expect_word(prev);
    end else begin
      r.status = ST_DONE;
      expect_word(r);
    end
  endtask

  task automatic predict_request(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] s,
                                 logic [SIZE_W-1:0] size, logic [COLD_W-1:0] cold);
    logic rl;
    rl = 1'b0;
    if (req == REQ_SPILL) begin
      predict_spill();
    end else if (req == REQ_REGISTER) begin
      tbl_valid[s] = 1'b1;
      tbl_bytes[s] = size;
      tbl_cold[s] = cold;
      tbl_pins[s] = '0;
      tbl_evicted[s] = 1'b0;
      expect_word(simple_result(ST_DONE, 1'b0));
    end else if (req > REQ_SPILL || !tbl_valid[s]) begin
      expect_word(simple_result(ST_IGNORED, 1'b0));
    end else if (req == REQ_UNREGISTER) begin
      tbl_valid[s] = 1'b0;
      tbl_pins[s] = '0;
      tbl_evicted[s] = 1'b0;
      expect_word(simple_result(ST_DONE, 1'b0));
    end else if (req == REQ_PIN) begin
      if (tbl_pins[s] != 16'hFFFF) tbl_pins[s]++;
      if (tbl_evicted[s]) begin
        tbl_evicted[s] = 1'b0;
        rl = 1'b1;
      end
      expect_word(simple_result(ST_DONE, rl));
    end else if (tbl_pins[s] == 0) begin
      expect_word(simple_result(ST_UNDERFLOW, 1'b0));
    end else begin
      tbl_pins[s]--;
      expect_word(simple_result(ST_DONE, 1'b0));
    end
  endtask

  // drain all results, then let the block settle before touching registers
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SPILL_EN: spill_en = val[0];
      CFG_BUDGET:   budget = val;
      CFG_HIGH_WM:  high_wm = val[WM_W-1:0];
      default:      low_wm = val[WM_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(logic en, logic [SIZE_W-1:0] bud, logic [WM_W-1:0] hw,
                            logic [WM_W-1:0] lw);
    wait_drained();
    write_cfg(CFG_SPILL_EN, SIZE_W'(en));
    write_cfg(CFG_BUDGET, bud);
    write_cfg(CFG_HIGH_WM, SIZE_W'(hw));
    write_cfg(CFG_LOW_WM, SIZE_W'(lw));
  endtask

  task automatic send_word(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] s,
                           logic [SIZE_W-1:0] size, logic [COLD_W-1:0] cold,
                           bit typed, logic [STAT_W-1:0] t_status, logic t_rl);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, cold, size, s, req};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(req, s, size, cold);
    if (typed) begin
      void'(pending_results.pop_back());
      expect_word(simple_result(t_status, t_rl));
    end
  endtask

  task automatic send_random();
    int                pick;
    logic [REQ_W-1:0]  req;
    logic [SIZE_W-1:0] size;
    logic [COLD_W-1:0] cold;
    pick = $urandom_range(99);
    if (pick < 36)      req = REQ_REGISTER;
    else if (pick < 44) req = REQ_UNREGISTER;
    else if (pick < 60) req = REQ_PIN;
    else if (pick < 74) req = REQ_UNPIN;
    else                req = REQ_SPILL;
    if (big_sizes || $urandom_range(19) == 0) size = SIZE_W'({$urandom, $urandom});
    else size = SIZE_W'($urandom_range(400));
    // narrow keys now and then to force coldness ties
    cold = ($urandom_range(3) == 0) ? COLD_W'($urandom_range(3)) : $urandom;
    send_word(req, SLOT_W'($urandom_range(15)), size, cold, 0, ST_DONE, 1'b0);
  endtask

  function automatic step_t rq(logic [REQ_W-1:0] req, logic [SLOT_W-1:0] s,
                               logic [SIZE_W-1:0] size, logic [COLD_W-1:0] cold,
                               bit typed = 0, logic [STAT_W-1:0] st = ST_DONE,
                               logic rl = 1'b0);
    step_t t;
    t = '{0, CFG_SPILL_EN, '0, req, s, size, cold, typed, st, rl};
    return t;
  endfunction

  function automatic step_t cw(logic [CIDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    step_t t;
    t = '{1, idx, val, REQ_SPILL, '0, '0, '0, 0, ST_DONE, 1'b0};
    return t;
  endfunction

  // receiver: random hold-off plus one long stall counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.reloaded = m_axis_tdata[2];
      got.evict_valid = m_axis_tdata[3];
      got.evict_slot = m_axis_tdata[7:4];
      got.freed_total = m_axis_tdata[51:8];
      got.resident_total = m_axis_tdata[95:52];
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h last %b", $time, m_axis_tdata,
                 m_axis_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.reloaded != want.reloaded) begin
          $display("%0t: reloaded exp %0d got %0d", $time, want.reloaded, got.reloaded);
          errors++;
        end
        if (got.evict_valid != want.evict_valid) begin
          $display("%0t: evict_valid exp %0d got %0d", $time, want.evict_valid,
                   got.evict_valid);
          errors++;
        end
        if (got.evict_slot != want.evict_slot) begin
          $display("%0t: evict_slot exp %0d got %0d", $time, want.evict_slot,
                   got.evict_slot);
          errors++;
        end
        if (got.freed_total != want.freed_total) begin
          $display("%0t: freed_total exp %0d got %0d", $time, want.freed_total,
                   got.freed_total);
          errors++;
        end
        if (got.resident_total != want.resident_total) begin
          $display("%0t: resident_total exp %0d got %0d", $time, want.resident_total,
                   got.resident_total);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL watermark_spill_eviction_table");
    $finish;
  end

  initial begin
    step_t st;
    for (int i = 0; i < 16; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_bytes[i] = '0;
      tbl_cold[i] = '0;
      tbl_pins[i] = '0;
      tbl_evicted[i] = 1'b0;
    end
    spill_en = 1'b1;
    budget = '0;
    high_wm = 17'd52429;
    low_wm = 17'd39322;

    // empty table, budget zero after reset
    add_step(rq(REQ_PIN, 4'd3, '0, '0, 1, ST_IGNORED));
    add_step(rq(REQ_UNPIN, 4'd15, '0, '0, 1, ST_IGNORED));
    add_step(rq(REQ_UNREGISTER, 4'd0, '0, '0, 1, ST_IGNORED));
    add_step(rq(REQ_SPILL, 4'd0, '0, '0, 1, ST_NO_SPILL));
    add_step(rq(REQ_REGISTER, 4'd0, {SIZE_W{1'b1}}, '1, 1, ST_DONE));
    add_step(rq(REQ_REGISTER, 4'd15, '0, '0, 1, ST_DONE));
    add_step(rq(REQ_UNPIN, 4'd0, '0, '0, 1, ST_UNDERFLOW));
    add_step(rq(REQ_PIN, 4'd0, '0, '0, 1, ST_DONE));
    add_step(rq(REQ_UNPIN, 4'd0, '0, '0, 1, ST_DONE));
    add_step(rq(REQ_UNREGISTER, 4'd0, '0, '0, 1, ST_DONE));
    // equal keys on slots 1 and 2: lower slot goes first
    add_step(cw(CFG_BUDGET, 40'd1000));
    add_step(rq(REQ_REGISTER, 4'd1, 40'd500, 32'd7));
    add_step(rq(REQ_REGISTER, 4'd2, 40'd500, 32'd7));
    add_step(rq(REQ_REGISTER, 4'd3, 40'd100, 32'd9));
    add_step(rq(REQ_SPILL, '0, '0, '0));
    add_step(rq(REQ_PIN, 4'd1, '0, '0, 1, ST_DONE, 1'b1));
    add_step(rq(REQ_PIN, 4'd2, '0, '0));
    add_step(rq(REQ_PIN, 4'd3, '0, '0));
    // everything pinned: nothing to evict
    add_step(rq(REQ_SPILL, '0, '0, '0));
    add_step(cw(CFG_SPILL_EN, 40'd0));
    add_step(rq(REQ_SPILL, '0, '0, '0, 1, ST_NO_SPILL));
    add_step(cw(CFG_SPILL_EN, 40'd1));
    add_step(cw(CFG_HIGH_WM, 40'd65536));
    add_step(cw(CFG_LOW_WM, 40'd0));
    add_step(rq(REQ_REGISTER, 4'd4, {SIZE_W{1'b1}}, 32'd1));
    add_step(rq(REQ_SPILL, '0, '0, '0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.is_cfg) begin
        wait_drained();
        write_cfg(st.cidx, st.cval);
      end else begin
        send_word(st.req, st.slot, st.size, st.cold, st.typed, st.t_status,
                  st.t_reloaded);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(1'b1, 40'd1000, 17'd52429, 17'd39322);
        1: set_config(1'b1, {SIZE_W{1'b1}}, 17'd65536, 17'd0);
        2: set_config(1'b1, 40'd700, 17'd0, 17'd0);
        default: set_config(1'b1, 40'd2500, 17'd32768, 17'd16384);
      endcase
      big_sizes = (ph == 1);
      tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 57 : 0;
      rx_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 12 : 0;
      if (ph == 1) hold_left = 300;
      for (int n = 0; n < 75; n++) begin
        // one pause for a full drain partway through
        if (ph == 2 && n == 40) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_random();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS watermark_spill_eviction_table");
    end else begin
      $display("FAIL watermark_spill_eviction_table");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/wses_pkg.sv
rtl/wses_ram.sv
rtl/wses_dp.sv
rtl/wses_ctrl.sv
rtl/watermark_spill_eviction_table.sv
tb/tb_watermark_spill_eviction_table.sv
